>>> rtl/buddy_page_allocator_macros.svh
// Assertion helpers shared by the allocator RTL.
`ifndef BUDDY_PAGE_ALLOCATOR_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define BPA_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("buddy allocator check failed");

// The consequent must hold in the cycle after the antecedent.
`define BPA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("buddy allocator check failed");

`else

`define BPA_ASSERT_IMPL(label, ante, cons)
`define BPA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> rtl/bpa_pkg.sv
`default_nettype none

package bpa_pkg;

	localparam int MAX_PAGES = 1024;
	localparam int NODES     = 2 * MAX_PAGES - 1;
	localparam int IDX_W     = $clog2(NODES);
	localparam int NODE_W    = $clog2(MAX_PAGES) + 1;
	localparam int PG_W      = $clog2(MAX_PAGES) + 2;
	localparam int CNT_W     = $clog2(MAX_PAGES) + 1;
	localparam int OFF_W     = $clog2(MAX_PAGES);

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_NO_SPACE = 2'd1,
		STATUS_BAD_FREE = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_A_ROOT,
		ST_A_DESC,
		ST_A_MARK,
		ST_F_WALK,
		ST_CLIMB_RD,
		ST_CLIMB_WR,
		ST_DONE
	} state_t;

	// Smallest power of two that is at least n, with zero treated as one.
	function automatic logic [PG_W-1:0] round_pow2(input logic [CNT_W-1:0] n);
		logic [CNT_W-1:0] r;
		logic [PG_W-1:0]  p;
		r = n - CNT_W'(1);
		p = PG_W'(1);
		if (n > CNT_W'(1)) begin
			for (int b = 0; b < CNT_W; b++) begin
				if (r[b]) begin
					p = PG_W'(2) << b;
				end
			end
		end
		return p;
	endfunction

endpackage

`default_nettype wire

>>> rtl/buddy_page_allocator.sv
`default_nettype none

// Buddy page allocator. Each node of a binary tree held in one on-chip memory
// keeps the largest free power-of-two block of its subtree. An allocate walks
// down from the root to the leftmost node that fits, one memory read per level,
// clears it and then climbs back to the root, reading the sibling and writing
// the parent at each level. A free climbs from the page's leaf to the first
// allocated node, restores it and merges buddies on the same climb back up.
// Items are handled one at a time. The pace of a walk is set by the single read
// port of the memory that every level of the walk goes through. After reset and
// after every write of total_pages the whole tree memory (2047 entries) is
// rebuilt, one entry per cycle, and no item is taken during that pass. Results
// sit in an output register, so the block finishes its next item while a result
// is stalled.

module buddy_page_allocator
	import bpa_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              total_pages_we,
	input  wire logic [CNT_W-1:0]  total_pages,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              mode,
	input  wire logic [CNT_W-1:0]  page_count,
	input  wire logic [OFF_W-1:0]  page_offset,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [1:0]             status,
	output logic [OFF_W-1:0]       block_offset,
	output logic [CNT_W-1:0]       block_pages,
	output logic [CNT_W-1:0]       avail_pages
);

	`include "buddy_page_allocator_macros.svh"

	// The tree memory: one write and one registered read per cycle.
	logic [NODE_W-1:0] tree_mem [NODES];
	logic              mem_we;
	logic [IDX_W-1:0]  mem_wa;
	logic [NODE_W-1:0] mem_wd;
	logic              mem_re;
	logic [IDX_W-1:0]  mem_ra;
	logic [NODE_W-1:0] rd_data_s1;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			tree_mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_data_s1 <= tree_mem[mem_ra];
		end
	end

	state_t state_q, state_d;

	// Control and bookkeeping registers.
	logic [PG_W-1:0]  leaves_q, leaves_d;
	logic [CNT_W-1:0] fcount_q, fcount_d;
	logic [IDX_W-1:0] sweep_idx_q, sweep_idx_d;
	logic [PG_W-1:0]  sweep_span_q, sweep_span_d;
	logic             out_valid_q, out_valid_d;

	// Per-operation working registers.
	logic             mode_q, mode_d;
	logic [PG_W-1:0]  need_q, need_d;
	logic [OFF_W-1:0] off_q, off_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [PG_W-1:0]  span_q, span_d;
	logic [PG_W-1:0]  val_q, val_d;
	logic [OFF_W-1:0] boff_q, boff_d;
	logic [PG_W-1:0]  bpages_q, bpages_d;
	status_t          stat_q, stat_d;

	// Result register.
	logic [1:0]       o_status_q, o_status_d;
	logic [OFF_W-1:0] o_boff_q, o_boff_d;
	logic [CNT_W-1:0] o_bpages_q, o_bpages_d;
	logic [CNT_W-1:0] o_free_q, o_free_d;

	// Shared decode of the current step.
	logic             in_xfer;
	logic             out_free;
	logic [CNT_W-1:0] in_req;
	logic [PG_W-1:0]  in_need;
	logic [PG_W-1:0]  eff_total;
	logic [PG_W-1:0]  rd_ext;
	logic             sweep_last;
	logic [IDX_W-1:0] parent_idx;
	logic [IDX_W-1:0] sibling_idx;
	logic [IDX_W-1:0] desc_idx;
	logic [PG_W-1:0]  half_span;
	logic             alloc_reject;
	logic             free_reject;
	logic [PG_W-1:0]  climb_span;
	logic [PG_W-1:0]  merged_val;
	logic [PG_W:0]    free_sum;

	assign in_stall     = (state_q != ST_IDLE);
	assign in_xfer      = in_valid && !in_stall;
	assign out_free     = !out_valid_q || !out_stall;
	assign in_req       = (page_count == '0) ? CNT_W'(1) : page_count;
	assign in_need      = round_pow2(page_count);
	assign rd_ext       = PG_W'(rd_data_s1);
	assign sweep_last   = (sweep_idx_q == IDX_W'(NODES - 1));
	assign parent_idx   = (idx_q - IDX_W'(1)) >> 1;
	assign sibling_idx  = idx_q[0] ? (idx_q + IDX_W'(1)) : (idx_q - IDX_W'(1));
	assign half_span    = span_q >> 1;
	assign desc_idx     = (rd_ext >= need_q) ? ((idx_q << 1) + IDX_W'(1))
	                                         : ((idx_q << 1) + IDX_W'(2));
	assign alloc_reject = (in_req > fcount_q) || (in_need > leaves_q);
	assign free_reject  = (PG_W'(page_offset) >= leaves_q);
	assign climb_span   = span_q << 1;
	assign free_sum     = (PG_W + 1)'(fcount_q) + (PG_W + 1)'(need_q);

	// Parent value from the node just written and its sibling; a free also
	// joins two whole buddies into one block.
	always_comb begin
		if (mode_q && (val_q + rd_ext == climb_span)) begin
			merged_val = climb_span;
		end else if (val_q > rd_ext) begin
			merged_val = val_q;
		end else begin
			merged_val = rd_ext;
		end
	end

	// A total of zero acts as one page, any total above the maximum as the maximum.
	always_comb begin
		if (total_pages == '0) begin
			eff_total = PG_W'(1);
		end else if (PG_W'(total_pages) > PG_W'(MAX_PAGES)) begin
			eff_total = PG_W'(MAX_PAGES);
		end else begin
			eff_total = PG_W'(total_pages);
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_SWEEP: begin
				if (sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_xfer) begin
					if (mode ? free_reject : alloc_reject) begin
						state_d = ST_DONE;
					end else begin
						state_d = mode ? ST_F_WALK : ST_A_ROOT;
					end
				end
			end
			ST_A_ROOT: begin
				if (rd_ext < need_q) begin
					state_d = ST_DONE;
				end else if (leaves_q == need_q) begin
					state_d = ST_A_MARK;
				end else begin
					state_d = ST_A_DESC;
				end
			end
			ST_A_DESC: begin
				if (half_span == need_q) begin
					state_d = ST_A_MARK;
				end
			end
			ST_A_MARK: begin
				state_d = (idx_q == '0) ? ST_DONE : ST_CLIMB_RD;
			end
			ST_F_WALK: begin
				if (rd_data_s1 == '0) begin
					state_d = (idx_q == '0) ? ST_DONE : ST_CLIMB_RD;
				end else if (idx_q == '0) begin
					state_d = ST_DONE;
				end
			end
			ST_CLIMB_RD: begin
				state_d = ST_CLIMB_WR;
			end
			ST_CLIMB_WR: begin
				state_d = (parent_idx == '0) ? ST_DONE : ST_CLIMB_RD;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (total_pages_we) begin
			state_d = ST_SWEEP;
		end
	end

	// Datapath, memory access and result register.
	always_comb begin
		leaves_d     = leaves_q;
		fcount_d     = fcount_q;
		sweep_idx_d  = sweep_idx_q;
		sweep_span_d = sweep_span_q;
		out_valid_d  = out_valid_q && out_stall;
		mode_d       = mode_q;
		need_d       = need_q;
		off_d        = off_q;
		idx_d        = idx_q;
		span_d       = span_q;
		val_d        = val_q;
		boff_d       = boff_q;
		bpages_d     = bpages_q;
		stat_d       = stat_q;
		o_status_d   = o_status_q;
		o_boff_d     = o_boff_q;
		o_bpages_d   = o_bpages_q;
		o_free_d     = o_free_q;
		mem_we       = 1'b0;
		mem_wa       = idx_q;
		mem_wd       = '0;
		mem_re       = 1'b0;
		mem_ra       = idx_q;

		case (state_q)
			ST_SWEEP: begin
				// Node i inside the live tree gets the span of its level, any other node
				// zero; the span halves at the first node of every level.
				mem_we      = 1'b1;
				mem_wa      = sweep_idx_q;
				if ((PG_W'(sweep_idx_q) < ((leaves_q << 1) - PG_W'(1)))) begin
					mem_wd = NODE_W'(((((sweep_idx_q + IDX_W'(1)) & sweep_idx_q) == '0)
					                  ? (sweep_span_q >> 1) : sweep_span_q));
				end
				if (((sweep_idx_q + IDX_W'(1)) & sweep_idx_q) == '0) begin
					sweep_span_d = sweep_span_q >> 1;
				end
				sweep_idx_d = sweep_idx_q + IDX_W'(1);
			end
			ST_IDLE: begin
				if (in_xfer) begin
					mode_d   = mode;
					need_d   = in_need;
					off_d    = page_offset;
					boff_d   = '0;
					bpages_d = '0;
					stat_d   = STATUS_OK;
					span_d   = PG_W'(1);
					if (mode) begin
						idx_d  = IDX_W'(leaves_q + PG_W'(page_offset) - PG_W'(1));
						mem_re = 1'b1;
						mem_ra = IDX_W'(leaves_q + PG_W'(page_offset) - PG_W'(1));
						if (free_reject) begin
							stat_d = STATUS_BAD_FREE;
						end
					end else begin
						idx_d  = '0;
						mem_re = 1'b1;
						mem_ra = '0;
						if (alloc_reject) begin
							stat_d = STATUS_NO_SPACE;
						end
					end
				end
			end
			ST_A_ROOT: begin
				idx_d  = '0;
				span_d = leaves_q;
				if (rd_ext < need_q) begin
					stat_d = STATUS_NO_SPACE;
				end else begin
					mem_re = 1'b1;
					mem_ra = IDX_W'(1);
				end
			end
			ST_A_DESC: begin
				idx_d  = desc_idx;
				span_d = half_span;
				if (rd_ext < need_q) begin
					boff_d = boff_q + OFF_W'(half_span);
				end
				mem_re = 1'b1;
				mem_ra = (desc_idx << 1) + IDX_W'(1);
			end
			ST_A_MARK: begin
				mem_we   = 1'b1;
				mem_wa   = idx_q;
				mem_wd   = '0;
				val_d    = '0;
				bpages_d = need_q;
				fcount_d = (PG_W'(fcount_q) > need_q) ? (fcount_q - CNT_W'(need_q)) : '0;
			end
			ST_F_WALK: begin
				if (rd_data_s1 == '0) begin
					mem_we   = 1'b1;
					mem_wa   = idx_q;
					mem_wd   = NODE_W'(span_q);
					val_d    = span_q;
					bpages_d = span_q;
					boff_d   = off_q & ~OFF_W'(span_q - PG_W'(1));
					fcount_d = (free_sum > (PG_W + 1)'(leaves_q)) ? CNT_W'(leaves_q)
					                                              : CNT_W'(free_sum);
				end else if (idx_q == '0) begin
					stat_d = STATUS_BAD_FREE;
				end else begin
					idx_d  = parent_idx;
					span_d = climb_span;
					mem_re = 1'b1;
					mem_ra = parent_idx;
				end
			end
			ST_CLIMB_RD: begin
				mem_re = 1'b1;
				mem_ra = sibling_idx;
			end
			ST_CLIMB_WR: begin
				mem_we = 1'b1;
				mem_wa = parent_idx;
				mem_wd = NODE_W'(merged_val);
				val_d  = merged_val;
				idx_d  = parent_idx;
				span_d = climb_span;
			end
			ST_DONE: begin
				if (out_free) begin
					out_valid_d = 1'b1;
					o_status_d  = stat_q;
					o_boff_d    = (stat_q == STATUS_OK) ? boff_q : '0;
					o_bpages_d  = (stat_q == STATUS_OK) ? CNT_W'(bpages_q) : '0;
					o_free_d    = fcount_q;
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase

		// A new total rebuilds the tree from scratch.
		if (total_pages_we) begin
			leaves_d     = round_pow2(CNT_W'(eff_total));
			fcount_d     = CNT_W'(eff_total);
			sweep_idx_d  = '0;
			sweep_span_d = round_pow2(CNT_W'(eff_total)) << 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_SWEEP;
			leaves_q     <= PG_W'(MAX_PAGES);
			fcount_q     <= CNT_W'(MAX_PAGES);
			sweep_idx_q  <= '0;
			sweep_span_q <= PG_W'(2 * MAX_PAGES);
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			leaves_q     <= leaves_d;
			fcount_q     <= fcount_d;
			sweep_idx_q  <= sweep_idx_d;
			sweep_span_q <= sweep_span_d;
			out_valid_q  <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		mode_q     <= mode_d;
		need_q     <= need_d;
		off_q      <= off_d;
		idx_q      <= idx_d;
		span_q     <= span_d;
		val_q      <= val_d;
		boff_q     <= boff_d;
		bpages_q   <= bpages_d;
		stat_q     <= stat_d;
		o_status_q <= o_status_d;
		o_boff_q   <= o_boff_d;
		o_bpages_q <= o_bpages_d;
		o_free_q   <= o_free_d;
	end

	assign out_valid    = out_valid_q;
	assign status       = o_status_q;
	assign block_offset = o_boff_q;
	assign block_pages  = o_bpages_q;
	assign avail_pages  = o_free_q;

	// A failed operation never reports a block.
	`BPA_ASSERT_IMPL(a_fail_no_block, out_valid_q && (o_status_q != STATUS_OK), (o_bpages_q == '0) && (o_boff_q == '0))
	// The free count never exceeds the tree's page span.
	`BPA_ASSERT_IMPL(a_count_bound, state_q != ST_SWEEP, PG_W'(fcount_q) <= leaves_q)
	// Outside the rebuild pass every write lands inside the live tree.
	`BPA_ASSERT_IMPL(a_write_in_tree, mem_we && (state_q != ST_SWEEP), PG_W'(mem_wa) < ((leaves_q << 1) - PG_W'(1)))
	// Every sibling read is followed by its climb write.
	`BPA_ASSERT_NEXT(a_read_then_write, (state_q == ST_CLIMB_RD) && !total_pages_we, state_q == ST_CLIMB_WR)

endmodule

`default_nettype wire
